/* rtl/core/fcca_pkg.sv */
package fcca_pkg;

   // Default sizing of the table
   localparam int TABLE_ENTRIES_DEF    = 128;
   localparam int RESERVED_ENTRIES_DEF = 16;

   // Field widths
   localparam int CMD_W     = 1;
   localparam int COUNT_W   = 8;
   localparam int CLUSTER_W = 7;
   localparam int STATUS_W  = 2;
   localparam int ENTRY_W   = 8;
   localparam int WIDE_W    = ENTRY_W + 1;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // Entry codes
   localparam logic [ENTRY_W-1:0] END_MARK  = 8'hff;
   localparam logic [ENTRY_W-1:0] FREE_MARK = 8'h00;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_BAD      = 2'd2
   } status_type;

   // How the walk index moves
   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_START,
      IDX_INC,
      IDX_LINK
   } idx_op_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       load_req;
      idx_op_type idx_op;
      logic       take;
      logic       wr_end;
      logic       wr_free;
      logic       steps_inc;
      logic       res_we;
      status_type res_status;
      logic       load_rsp;
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic is_alloc;
      logic count_zero;
      logic no_space;
      logic start_bad;
      logic entry_free;
      logic entry_end;
      logic link_bad;
      logic last_take;
      logic last_step;
      logic rsp_hold;
   } dp_stat_type;

endpackage

/* rtl/core/fcca_ram.sv */
module fcca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and read with new data on an address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/fcca_datapath.sv */
module fcca_datapath #(
   parameter int TABLE_ENTRIES    = fcca_pkg::TABLE_ENTRIES_DEF,
   parameter int RESERVED_ENTRIES = fcca_pkg::RESERVED_ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [fcca_pkg::CMD_W-1:0]     req_cmd,
   input  logic [fcca_pkg::COUNT_W-1:0]   req_count,
   input  logic [fcca_pkg::CLUSTER_W-1:0] req_start,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic [fcca_pkg::STATUS_W-1:0]  rsp_status,
   output logic [fcca_pkg::CLUSTER_W-1:0] rsp_first,
   input  fcca_pkg::dp_cmd_type           cmd,
   output fcca_pkg::dp_stat_type          stat
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int EW    = fcca_pkg::ENTRY_W;
   localparam int WW    = fcca_pkg::WIDE_W;

   localparam logic [WW-1:0] TE_WIDE  = WW'(TABLE_ENTRIES);
   localparam logic [WW-1:0] RES_WIDE = WW'(RESERVED_ENTRIES);

   // Latched request
   logic [fcca_pkg::CMD_W-1:0]     cmd_ff;
   logic [fcca_pkg::COUNT_W-1:0]   want_ff;
   logic [fcca_pkg::CLUSTER_W-1:0] start_ff;

   // Walk state
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] prev_ff;
   logic             have_prev_ff;
   logic [EW-1:0]    taken_ff;
   logic [CNT_W-1:0] steps_ff;
   logic [CNT_W-1:0] free_cnt_ff;
   logic [EW-1:0]    first_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;

   // Result
   fcca_pkg::status_type           res_status_ff;
   logic                           rsp_valid_ff;
   logic [fcca_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [fcca_pkg::CLUSTER_W-1:0] rsp_first_ff;

   // Table port
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [EW-1:0]    wr_data;
   logic [EW-1:0]    ram_rd;
   logic [EW-1:0]    entry;
   logic [EW-1:0]    start_wide;

   assign start_wide = EW'(start_ff);

   // Next walk index; the table is read at it every cycle
   always_comb begin
      case (cmd.idx_op)
         fcca_pkg::IDX_ZERO:  idx_in = '0;
         fcca_pkg::IDX_START: idx_in = start_wide[IDX_W-1:0];
         fcca_pkg::IDX_INC:   idx_in = idx_ff + IDX_W'(1);
         fcca_pkg::IDX_LINK:  idx_in = entry[IDX_W-1:0];
         default:             idx_in = idx_ff;
      endcase
   end

   // Select the single write: link, end mark or clear
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = fcca_pkg::FREE_MARK;
      if (cmd.take && have_prev_ff) begin
         wr_en   = 1'b1;
         wr_addr = prev_ff;
         wr_data = EW'(idx_ff);
      end else if (cmd.wr_end) begin
         wr_en   = 1'b1;
         wr_data = fcca_pkg::END_MARK;
      end else if (cmd.wr_free) begin
         wr_en   = 1'b1;
      end
   end

   fcca_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_in),
      .rd_data (ram_rd)
   );

   // Untouched entries read as their reset value
   always_comb begin
      if (valid_ff[idx_ff]) begin
         entry = ram_rd;
      end else if ({1'b0, EW'(idx_ff)} < RES_WIDE) begin
         entry = fcca_pkg::END_MARK;
      end else begin
         entry = fcca_pkg::FREE_MARK;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         free_cnt_ff  <= CNT_W'(TABLE_ENTRIES - RESERVED_ENTRIES);
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         have_prev_ff <= 1'b0;
         taken_ff     <= '0;
         steps_ff     <= '0;
      end else begin
         idx_ff <= idx_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.take) begin
            free_cnt_ff <= free_cnt_ff - CNT_W'(1);
         end else if (cmd.wr_free) begin
            free_cnt_ff <= free_cnt_ff + CNT_W'(1);
         end
         if (cmd.load_req) begin
            have_prev_ff <= 1'b0;
            taken_ff     <= '0;
            steps_ff     <= '0;
         end else begin
            if (cmd.take) begin
               have_prev_ff <= 1'b1;
               taken_ff     <= taken_ff + EW'(1);
            end
            if (cmd.steps_inc) begin
               steps_ff <= steps_ff + CNT_W'(1);
            end
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff   <= req_cmd;
         want_ff  <= req_count;
         start_ff <= req_start;
         first_ff <= '0;
      end else if (cmd.take && !have_prev_ff) begin
         first_ff <= EW'(idx_ff);
      end
      if (cmd.take) begin
         prev_ff <= idx_ff;
      end
      if (cmd.res_we) begin
         res_status_ff <= cmd.res_status;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_first_ff  <= (res_status_ff == fcca_pkg::ST_OK &&
                           cmd_ff == fcca_pkg::CMD_ALLOC) ?
                          first_ff[fcca_pkg::CLUSTER_W-1:0] : '0;
      end
   end

   // Status toward the controller
   always_comb begin
      stat.is_alloc   = (cmd_ff == fcca_pkg::CMD_ALLOC);
      stat.count_zero = (want_ff == '0);
      stat.no_space   = ({1'b0, want_ff} > WW'(free_cnt_ff));
      stat.start_bad  = (WW'(start_ff) >= TE_WIDE);
      stat.entry_free = (entry == fcca_pkg::FREE_MARK);
      stat.entry_end  = (entry == fcca_pkg::END_MARK);
      stat.link_bad   = ({1'b0, entry} >= TE_WIDE);
      stat.last_take  = (({1'b0, taken_ff} + WW'(1)) == {1'b0, want_ff});
      stat.last_step  = ((WW'(steps_ff) + WW'(1)) == TE_WIDE);
      stat.rsp_hold   = rsp_valid_ff && !rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_first  = rsp_first_ff;

endmodule

/* rtl/core/fcca_ctrl.sv */
module fcca_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  fcca_pkg::dp_stat_type stat,
   output fcca_pkg::dp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_ALLOC,
      S_END,
      S_FREE,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   // Sequence one item: decode, walk the table, post the result
   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      cmd            = '0;
      cmd.idx_op     = fcca_pkg::IDX_HOLD;
      cmd.res_status = fcca_pkg::ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            // Refuse items while reset is held
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.res_we = 1'b1;
            if (stat.is_alloc) begin
               if (stat.count_zero) begin
                  cmd.res_status = fcca_pkg::ST_BAD;
                  state_in       = S_DONE;
               end else if (stat.no_space) begin
                  cmd.res_status = fcca_pkg::ST_NO_SPACE;
                  state_in       = S_DONE;
               end else begin
                  cmd.idx_op = fcca_pkg::IDX_ZERO;
                  state_in   = S_ALLOC;
               end
            end else if (stat.start_bad) begin
               cmd.res_status = fcca_pkg::ST_BAD;
               state_in       = S_DONE;
            end else begin
               cmd.idx_op = fcca_pkg::IDX_START;
               state_in   = S_FREE;
            end
         end
         S_ALLOC: begin
            if (stat.entry_free) begin
               cmd.take = 1'b1;
               if (stat.last_take) begin
                  state_in = S_END;
               end else begin
                  cmd.idx_op = fcca_pkg::IDX_INC;
               end
            end else begin
               cmd.idx_op = fcca_pkg::IDX_INC;
            end
         end
         S_END: begin
            cmd.wr_end = 1'b1;
            state_in   = S_DONE;
         end
         S_FREE: begin
            if (stat.entry_free) begin
               state_in = S_DONE;
            end else begin
               cmd.wr_free = 1'b1;
               if (stat.entry_end || stat.link_bad || stat.last_step) begin
                  state_in = S_DONE;
               end else begin
                  cmd.idx_op    = fcca_pkg::IDX_LINK;
                  cmd.steps_inc = 1'b1;
               end
            end
         end
         S_DONE: begin
            if (!stat.rsp_hold) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/fat_cluster_chain_allocator_top.sv */
// Cluster allocation table of TABLE_ENTRIES byte entries (0 free, 0xff end of
// chain, else link to the next cluster); the first RESERVED_ENTRIES entries
// come out of reset end-marked. Each req item (tuser = cmd) either allocates
// a chain of count clusters, taken upward from entry 0, or frees the chain
// that starts at start_cluster; exactly one rsp item answers each request.
// One item is worked at a time, through the single table read port at one
// entry per cycle: an allocate walks upward from entry 0 until its last entry
// is claimed, a free walks the chain from start_cluster for at most
// TABLE_ENTRIES entries, and a rejected request skips the walk. The next
// request is taken while a result waits in the output register. Entries
// never written since reset read as their reset value through per-entry
// valid bits, so no clearing pass runs after reset.
module fat_cluster_chain_allocator_top #(
   parameter int TABLE_ENTRIES    = fcca_pkg::TABLE_ENTRIES_DEF,
   parameter int RESERVED_ENTRIES = fcca_pkg::RESERVED_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // count [7:0], start_cluster [14:8], zero [15]
   input  logic [fcca_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd [0]
   input  logic [fcca_pkg::CMD_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status [1:0], head_cluster [8:2], zero [15:9]
   output logic [fcca_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int CW = fcca_pkg::COUNT_W;
   localparam int LW = fcca_pkg::CLUSTER_W;
   localparam int SW = fcca_pkg::STATUS_W;

   fcca_pkg::dp_cmd_type  dp_cmd;
   fcca_pkg::dp_stat_type dp_stat;
   logic [SW-1:0]         rsp_status;
   logic [LW-1:0]         rsp_first;

   fcca_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (dp_stat),
      .cmd        (dp_cmd)
   );

   fcca_datapath #(
      .TABLE_ENTRIES    (TABLE_ENTRIES),
      .RESERVED_ENTRIES (RESERVED_ENTRIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_cmd    (req_tuser),
      .req_count  (req_tdata[CW-1:0]),
      .req_start  (req_tdata[CW+LW-1:CW]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_status (rsp_status),
      .rsp_first  (rsp_first),
      .cmd        (dp_cmd),
      .stat       (dp_stat)
   );

   // Pack the result item
   assign rsp_tdata = {{(fcca_pkg::RSP_DATA_W - SW - LW){1'b0}}, rsp_first, rsp_status};

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import fcca_pkg::*;

   localparam int FAT_ENTRIES   = TABLE_ENTRIES_DEF;
   localparam int FAT_RESERVED  = RESERVED_ENTRIES_DEF;
   localparam int HOLD_OFF_LEN  = 400;
   localparam int DRAIN_CYCLES  = 2 * FAT_ENTRIES + 16;

   typedef struct {
      status_type             status;
      logic [CLUSTER_W-1:0]   first;
      bit                     freed;
   } alloc_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic [CMD_W-1:0]        req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;

   // Shadow copy of the allocation table and the results still owed
   logic [ENTRY_W-1:0]      fat_shadow [FAT_ENTRIES];
   alloc_result_type        pending_results [$];
   logic [CLUSTER_W-1:0]    live_heads [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_off_left  = 0;
   int error_count    = 0;
   int seen_alloc_ok  = 0;
   int seen_no_space  = 0;
   int seen_bad       = 0;
   int seen_free      = 0;

   fat_cluster_chain_allocator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Work out the answer to one accepted request and update the shadow table
   function void predict_request(cmd_type cmd, logic [COUNT_W-1:0] count,
                                 logic [CLUSTER_W-1:0] start);
      alloc_result_type res;
      int free_total;
      int taken;
      int prev;
      int pos;
      int link;
      bit done;
      res.status = ST_OK;
      res.first  = '0;
      res.freed  = (cmd == CMD_FREE);
      if (cmd == CMD_ALLOC) begin
         if (count == 0) begin
            res.status = ST_BAD;
         end else begin
            free_total = 0;
            foreach (fat_shadow[i])
               if (fat_shadow[i] == FREE_MARK) free_total++;
            if (free_total < int'(count)) begin
               res.status = ST_NO_SPACE;
            end else begin
               taken = 0;
               prev  = -1;
               for (int i = 0; i < FAT_ENTRIES && taken < int'(count); i++) begin
                  if (fat_shadow[i] == FREE_MARK) begin
                     // link the previous claim here, end-mark this one
                     if (prev < 0) res.first = CLUSTER_W'(i);
                     else fat_shadow[prev] = ENTRY_W'(i);
                     fat_shadow[i] = END_MARK;
                     prev = i;
                     taken++;
                  end
               end
               live_heads.push_back(res.first);
            end
         end
      end else if (int'(start) >= FAT_ENTRIES) begin
         res.status = ST_BAD;
      end else begin
         // walk the chain, zeroing up to and including the end mark
         pos  = start;
         done = 1'b0;
         for (int steps = 0; steps < FAT_ENTRIES && !done; steps++) begin
            if (pos >= FAT_ENTRIES) begin
               done = 1'b1;
            end else begin
               link = fat_shadow[pos];
               if (link == FREE_MARK) begin
                  done = 1'b1;
               end else begin
                  fat_shadow[pos] = FREE_MARK;
                  if (link == END_MARK) done = 1'b1;
                  else pos = link;
               end
            end
         end
      end
      pending_results.push_back(res);
   endfunction

   // Offer one request, hold it until accepted, then predict its answer
   task automatic send_request(cmd_type cmd, logic [COUNT_W-1:0] count,
                               logic [CLUSTER_W-1:0] start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, start, count};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_request(cmd, count, start);
   endtask

   // Receiver: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_tready <= 1'b0;
         hold_off_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Compare each answer with the oldest prediction
   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result item: tdata %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[1:0] !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tdata[1:0]);
               error_count++;
            end
            if (rsp_tdata[8:2] !== want.first) begin
               $error("head_cluster: expected %0d, actual %0d", want.first,
                      rsp_tdata[8:2]);
               error_count++;
            end
            if (rsp_tdata[15:9] !== '0) begin
               $error("pad: expected 0, actual %0d", rsp_tdata[15:9]);
               error_count++;
            end
            case (want.status)
               ST_NO_SPACE: seen_no_space++;
               ST_BAD:      seen_bad++;
               default:     if (want.freed) seen_free++;
                            else seen_alloc_ok++;
            endcase
         end
      end
   end

   // Edges of count and start, full and empty table, reserved entries
   task automatic run_directed_cases();
      send_request(CMD_ALLOC, 8'd0, 7'd0);
      send_request(CMD_ALLOC, 8'd255, 7'd127);
      send_request(CMD_ALLOC, 8'(FAT_ENTRIES - FAT_RESERVED + 1), 7'd0);
      send_request(CMD_ALLOC, 8'(FAT_ENTRIES - FAT_RESERVED), 7'd0);
      send_request(CMD_ALLOC, 8'd1, 7'd0);
      send_request(CMD_FREE, 8'd0, 7'(FAT_RESERVED));
      // freeing again runs into a free entry and stops
      send_request(CMD_FREE, 8'd255, 7'(FAT_RESERVED));
      send_request(CMD_FREE, 8'd0, 7'd127);
      // release every reserved entry, then claim the whole table
      for (int i = 0; i < FAT_RESERVED; i++)
         send_request(CMD_FREE, 8'd0, 7'(i));
      send_request(CMD_ALLOC, 8'(FAT_ENTRIES), 7'd0);
      send_request(CMD_FREE, 8'd0, 7'd0);
      live_heads.delete();
   endtask

   // Mostly small allocations and frees of live chains, plus odd requests
   task automatic run_random_phase(int items, int idle_pct, int stall_pct);
      int pick;
      int idx;
      logic [CLUSTER_W-1:0] head;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < items; n++) begin
         pick = $urandom_range(99);
         if (pick < 45 && live_heads.size() > 0) begin
            idx  = $urandom_range(live_heads.size() - 1);
            head = live_heads[idx];
            live_heads.delete(idx);
            send_request(CMD_FREE, 8'($urandom), head);
         end else if (pick < 80) begin
            send_request(CMD_ALLOC,
                         8'(($urandom_range(3) == 0) ? $urandom_range(40, 9)
                                                     : $urandom_range(8, 1)),
                         7'($urandom));
         end else if (pick < 85) begin
            send_request(CMD_ALLOC, 8'($urandom_range(128, 41)), 7'($urandom));
         end else if (pick < 90) begin
            send_request(CMD_ALLOC,
                         8'(($urandom_range(3) == 0) ? 0 : $urandom_range(255, 129)),
                         7'($urandom));
         end else begin
            send_request(CMD_FREE, 8'($urandom), 7'($urandom_range(127)));
         end
      end
   endtask

   // Hold the receiver off while requests keep coming, so the input backs up
   task automatic run_long_stall();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_left  = HOLD_OFF_LEN;
      for (int n = 0; n < 20; n++) begin
         if (n % 2 == 0) send_request(CMD_ALLOC, 8'($urandom_range(4, 1)), 7'd0);
         else if (live_heads.size() > 0)
            send_request(CMD_FREE, 8'd0, live_heads.pop_front());
         else send_request(CMD_FREE, 8'd0, 7'd0);
      end
   endtask

   initial begin
      // Shadow table starts as the block does out of reset
      foreach (fat_shadow[i])
         fat_shadow[i] = (i < FAT_RESERVED) ? END_MARK : FREE_MARK;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      run_directed_cases();
      run_random_phase(300, 0, 0);
      run_random_phase(300, 72, 0);
      run_long_stall();
      run_random_phase(300, 0, 72);
      run_random_phase(300, 12, 12);
      req_tvalid <= 1'b0;
      while (pending_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d chain allocations, %0d refused for space, %0d bad requests,",
               seen_alloc_ok, seen_no_space, seen_bad);
      $display("%0d frees, under idle, stall and long hold-off traffic", seen_free);
      if (error_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   // Give up on a hung run
   initial begin
      #5_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule

/* fat_cluster_chain_allocator_top.f */
rtl/core/fcca_pkg.sv
rtl/core/fcca_ram.sv
rtl/core/fcca_datapath.sv
rtl/core/fcca_ctrl.sv
rtl/core/fat_cluster_chain_allocator_top.sv
tb/sv/testbench.sv
